FILE: rtl/assert_macros.svh
// Assertion macros for the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define CHK_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lires_pkg.sv
// Types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps
package lires_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int OUT_W      = 16;
	localparam int RAW_W      = 64;
	localparam int STEP_W     = 30;
	localparam int PHASE_W    = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 6;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_IS_FLOAT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SIZE     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VALID    = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_STEREO   = 2'd3;

	// Container size codes
	localparam logic [2:0] SZ_8  = 3'd0;
	localparam logic [2:0] SZ_16 = 3'd1;
	localparam logic [2:0] SZ_24 = 3'd2;
	localparam logic [2:0] SZ_32 = 3'd3;
	localparam logic [2:0] SZ_64 = 3'd4;

	localparam logic signed [SAMPLE_W-1:0] Q_MAX    = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] Q_MIN    = 24'sh800000;
	localparam logic signed [SAMPLE_W-1:0] SAT16_HI = 24'sd8388352;
	localparam logic [14:0]                SCALE16  = 15'd32767;

	typedef struct packed {
		logic [RAW_W-1:0]  left_raw;
		logic [RAW_W-1:0]  right_raw;
		logic [STEP_W-1:0] step;
		logic              silent;
		logic              discontinuity;
		logic              packet_last;
	} lires_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left_out;
		logic signed [OUT_W-1:0] right_out;
		logic                    last;
	} lires_out_t;

	typedef struct packed {
		logic       fp_en;
		logic [2:0] sample_size_code;
		logic [5:0] sig_bits;
	} lires_fmt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC_L,
		ST_DEC_R,
		ST_CHECK,
		ST_MUL,
		ST_RND,
		ST_SCL,
		ST_FIN,
		ST_EMIT,
		ST_DONE
	} lires_state_t;

endpackage

FILE: rtl/lires_dec.sv
// Sample decoder: PCM or IEEE float container word to Q1.23.
`timescale 1ns / 1ps
module lires_dec import lires_pkg::*; (
	input  lires_fmt_t                   fmt,
	input  logic [RAW_W-1:0]             raw,
	output logic signed [SAMPLE_W-1:0]   sample
);

	logic [5:0]         pcm_bits, pcm_vb, pcm_k, pcm_lsh;
	logic [3:0]         pcm_sh;
	logic signed [32:0] pcm_s, pcm_x, pcm_lo;
	logic signed [33:0] pcm_q, pcm_r;
	logic [7:0]         pcm_mask, pcm_rem, pcm_half;
	logic signed [SAMPLE_W-1:0] pcm_val;

	logic [10:0] fl_ef, fl_bias;
	logic        fl_neg, fl_hid, fl_inf, fl_up;
	logic [52:0] fl_m, fl_q, fl_rem, fl_half, fl_mask;
	logic [11:0] fl_dist;
	logic [5:0]  fl_sh;
	logic [24:0] fl_mag;
	logic signed [SAMPLE_W-1:0] fl_val;

	// Integer PCM
	always_comb begin
		unique case (fmt.sample_size_code)
			SZ_16:   pcm_bits = 6'd16;
			SZ_24:   pcm_bits = 6'd24;
			default: pcm_bits = 6'd32;
		endcase
		pcm_vb = (fmt.sig_bits == 6'd0 || fmt.sig_bits > pcm_bits) ? pcm_bits
			: fmt.sig_bits;
		pcm_k = pcm_bits - pcm_vb;
		unique case (fmt.sample_size_code)
			SZ_16:   pcm_s = {{17{raw[15]}}, raw[15:0]};
			SZ_24:   pcm_s = {{9{raw[23]}}, raw[23:0]};
			default: pcm_s = {raw[31], raw[31:0]};
		endcase
		// drop the padding bits (floor)
		pcm_x   = pcm_s >>> pcm_k;
		pcm_lsh = 6'd24 - pcm_vb;
		pcm_lo  = pcm_x <<< pcm_lsh;
		// more than 24 valid bits: round to nearest even
		pcm_sh   = 4'(pcm_vb - 6'd24);
		pcm_q    = 34'(pcm_x >>> pcm_sh);
		pcm_mask = 8'((9'd1 << pcm_sh) - 9'd1);
		pcm_rem  = pcm_x[7:0] & pcm_mask;
		pcm_half = 8'(9'd1 << (pcm_sh - 4'd1));
		pcm_r    = pcm_q + 34'((pcm_rem > pcm_half || (pcm_rem == pcm_half && pcm_q[0]))
			? 1 : 0);
		if (fmt.sample_size_code == SZ_8) begin
			pcm_val = {~raw[7], raw[6:0], 16'h0000};
		end else if (fmt.sample_size_code > SZ_32) begin
			pcm_val = '0;
		end else if (pcm_vb <= 6'd24) begin
			pcm_val = pcm_lo[SAMPLE_W-1:0];
		end else if (pcm_r > 34'sd8388607) begin
			pcm_val = Q_MAX;
		end else begin
			pcm_val = pcm_r[SAMPLE_W-1:0];
		end
	end

	// IEEE float, single widened onto the double mantissa grid
	always_comb begin
		if (fmt.sample_size_code == SZ_32) begin
			fl_ef   = {3'b000, raw[30:23]};
			fl_bias = 11'd127;
			fl_inf  = &raw[30:23];
			fl_hid  = |raw[30:23];
			fl_m    = {fl_hid, raw[22:0], 29'h0};
			fl_neg  = raw[31];
		end else begin
			fl_ef   = raw[62:52];
			fl_bias = 11'd1023;
			fl_inf  = &raw[62:52];
			fl_hid  = |raw[62:52];
			fl_m    = {fl_hid, raw[51:0]};
			fl_neg  = raw[63];
		end
		fl_dist = {1'b0, fl_bias} - {1'b0, fl_ef};
		fl_sh   = 6'(12'd29 + fl_dist);
		fl_q    = fl_m >> fl_sh;
		fl_mask = (53'd1 << fl_sh) - 53'd1;
		fl_rem  = fl_m & fl_mask;
		fl_half = 53'd1 << (fl_sh - 6'd1);
		fl_up   = fl_rem > fl_half || (fl_rem == fl_half && fl_q[0]);
		if (fl_ef >= fl_bias) begin
			fl_mag = 25'h0800000;
		end else if (fl_dist > 12'd24) begin
			fl_mag = '0;
		end else begin
			fl_mag = fl_q[24:0] + 25'(fl_up);
		end
		// clamp to [-1, 1 - lsb]; NaN and infinity give zero
		if (fl_inf) begin
			fl_val = '0;
		end else if (fl_mag >= 25'h0800000) begin
			fl_val = fl_neg ? Q_MIN : Q_MAX;
		end else begin
			fl_val = fl_neg ? -$signed(fl_mag[SAMPLE_W-1:0]) : $signed(fl_mag[SAMPLE_W-1:0]);
		end
	end

	// Pick the format
	always_comb begin
		if (!fmt.fp_en) begin
			sample = pcm_val;
		end else if (fmt.sample_size_code == SZ_32 || fmt.sample_size_code == SZ_64) begin
			sample = fl_val;
		end else begin
			sample = '0;
		end
	end

endmodule

FILE: rtl/linear_interp_audio_resampler.sv
// Top level of the linear interpolation audio resampler.
//
//  channel   direction  handshake            transaction
//  in        sink       in_valid/in_stall    one captured stereo frame (lires_in_t)
//  out       source     out_valid/out_stall  one 16-bit stereo frame (lires_out_t)
//  cfg       sink       cfg_we               one register write, no wait
//
//  An input frame gives N results, N = 0..MAX_OUTPUTS; a frame that only primes the
//  history (none held yet) gives none. Left is decoded, then right, then per result
//  two passes (left, right) go through the single shared multiplier, each pass stepping
//  ST_MUL, ST_RND, ST_SCL and ST_FIN. in_stall is high from acceptance until the phase
//  update is written back, or for a priming frame until it is stored as history.
//  A result sits in the output register; the next result waits while out_stall holds it.
//  Reset clears control state, phase and history, not the datapath; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linear_interp_audio_resampler import lires_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 28,
	parameter int MAX_OUTPUTS     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lires_in_t             in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lires_out_t            out_data
);

	localparam int F      = PHASE_FRAC_BITS;
	localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);
	localparam int PROD_W = F + 26;
	localparam int T_W    = PROD_W + 1;
	localparam logic [PHASE_W-1:0] PH_ONE   = PHASE_W'(64'd1 << F);
	localparam logic [PHASE_W-1:0] MIN_STEP =
		PHASE_W'(((64'd1 << F) + 64'(MAX_OUTPUTS) - 64'd1) / 64'(MAX_OUTPUTS));

	lires_state_t state_q, state_nx;

	logic       fp_en_q, stereo_q;
	logic [2:0] size_q;
	logic [5:0] sig_bits_q;
	lires_fmt_t fmt;

	lires_in_t                  item_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [SAMPLE_W-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q, dec_sample;
	logic                       have_prev_q, ch_q;
	logic [PHASE_W-1:0]         phase_q, ph_q, ph_next, ph_fin, ph_thr;
	logic [CNT_W-1:0]           n_q;

	logic signed [24:0]         mul_a;
	logic [F-1:0]               mul_b;
	logic signed [PROD_W-1:0]   mul_p, prod_q;
	logic signed [T_W-1:0]      t_sum, t_q;
	logic [F-1:0]               t_rem, t_half;
	logic signed [SAMPLE_W-1:0] v_q, pa, ca;
	logic                       sat_hi_q, sat_lo_q;
	logic signed [PROD_W-1:0]   r_q;
	logic [22:0]                r_rem;
	logic signed [OUT_W-1:0]    r16, res_l_q, res_r_q;

	logic       slot_free, out_load, out_last;
	lires_out_t out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_en_q    <= 1'b0;
			size_q     <= SZ_16;
			sig_bits_q <= 6'd16;
			stereo_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IS_FLOAT: fp_en_q    <= cfg_wdata[0];
				REG_SIZE:     size_q     <= cfg_wdata[2:0];
				REG_VALID:    sig_bits_q <= cfg_wdata;
				REG_STEREO:   stereo_q   <= cfg_wdata[0];
			endcase
		end
	end

	assign fmt = '{fp_en: fp_en_q, sample_size_code: size_q, sig_bits: sig_bits_q};

	// Decode left, then right (mono reuses the left word)
	lires_dec u_dec (
		.fmt    (fmt),
		.raw    ((state_q == ST_DEC_L || !stereo_q) ? item_q.left_raw : item_q.right_raw),
		.sample (dec_sample)
	);

	// Shared multiplier operands
	assign pa = ch_q ? prev_r_q : prev_l_q;
	assign ca = ch_q ? cur_r_q : cur_l_q;
	always_comb begin
		if (state_q == ST_SCL) begin
			mul_a = 25'(v_q);
			mul_b = F'(SCALE16);
		end else begin
			mul_a = 25'(ca) - 25'(pa);
			mul_b = ph_q[F-1:0];
		end
	end
	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// Interpolated Q1.23, round to nearest even
	assign t_sum  = (T_W'(pa) <<< F) + T_W'(prod_q);
	assign t_q    = t_sum >>> F;
	assign t_rem  = t_sum[F-1:0];
	assign t_half = {1'b1, {(F-1){1'b0}}};

	// Scale to 16 bits, round to nearest even
	assign r_q   = prod_q >>> 23;
	assign r_rem = prod_q[22:0];
	always_comb begin
		if (sat_hi_q) begin
			r16 = 16'sh7FFF;
		end else if (sat_lo_q) begin
			r16 = 16'sh8000;
		end else begin
			r16 = r_q[OUT_W-1:0] + OUT_W'((r_rem > 23'h400000 ||
				(r_rem == 23'h400000 && r_q[0])) ? 1 : 0);
		end
	end

	// Phase arithmetic
	assign ph_next  = ph_q + {2'b00, step_q};
	assign out_last = !(ph_next < PH_ONE && n_q + CNT_W'(1) < CNT_W'(MAX_OUTPUTS));
	assign ph_fin   = (ph_q >= PH_ONE) ? ph_q - PH_ONE : '0;
	assign ph_thr   = {2'b00, step_q} + PH_ONE;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_DEC_L;
			ST_DEC_L: state_nx = ST_DEC_R;
			ST_DEC_R: state_nx = ST_CHECK;
			ST_CHECK: begin
				if (!have_prev_q) state_nx = ST_IDLE;
				else if (ph_q < PH_ONE && n_q < CNT_W'(MAX_OUTPUTS)) state_nx = ST_MUL;
				else state_nx = ST_DONE;
			end
			ST_MUL:   state_nx = ST_RND;
			ST_RND:   state_nx = ST_SCL;
			ST_SCL:   state_nx = ST_FIN;
			ST_FIN:   state_nx = ch_q ? ST_EMIT : ST_MUL;
			ST_EMIT:  if (slot_free) state_nx = ST_CHECK;
			ST_DONE:  state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		slot_free = !out_valid || !out_stall;
		out_load  = (state_q == ST_EMIT) && slot_free;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			phase_q     <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			n_q         <= '0;
			ch_q        <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_nx;
			// a discontinuity drops the history before this frame
			if (state_q == ST_IDLE && in_valid && in_data.discontinuity) begin
				have_prev_q <= 1'b0;
				phase_q     <= '0;
				prev_l_q    <= '0;
				prev_r_q    <= '0;
			end
			if (state_q == ST_DEC_L) begin
				n_q  <= '0;
				ch_q <= 1'b0;
			end
			if (state_q == ST_CHECK && !have_prev_q) begin
				prev_l_q    <= cur_l_q;
				prev_r_q    <= cur_r_q;
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_FIN) ch_q <= ~ch_q;
			if (out_load) n_q <= n_q + CNT_W'(1);
			// write back phase and history
			if (state_q == ST_DONE) begin
				phase_q  <= (item_q.packet_last && ph_fin > ph_thr) ? '0 : ph_fin;
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
			end
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
			step_q <= ({2'b00, in_data.step} < MIN_STEP) ? MIN_STEP[STEP_W-1:0]
				: in_data.step;
		end
		if (state_q == ST_DEC_L) begin
			cur_l_q <= item_q.silent ? '0 : dec_sample;
			ph_q    <= phase_q;
		end
		if (state_q == ST_DEC_R) cur_r_q <= item_q.silent ? '0 : dec_sample;
		if (state_q == ST_MUL) prod_q <= mul_p;
		if (state_q == ST_RND) begin
			v_q <= t_q[SAMPLE_W-1:0] + SAMPLE_W'((t_rem > t_half ||
				(t_rem == t_half && t_q[0])) ? 1 : 0);
		end
		if (state_q == ST_SCL) begin
			prod_q   <= mul_p;
			sat_hi_q <= (v_q >= SAT16_HI);
			sat_lo_q <= (v_q == Q_MIN);
		end
		if (state_q == ST_FIN) begin
			if (ch_q) res_r_q <= r16;
			else res_l_q <= r16;
		end
		if (out_load) begin
			out_q <= '{left_out: res_l_q, right_out: res_r_q, last: out_last};
			ph_q  <= ph_next;
		end
	end

	assign out_data = out_q;

	`CHK_NOW(a_cnt_cap, clk, arst_n, 1'b1, n_q <= CNT_W'(MAX_OUTPUTS), "result count over cap")
	`CHK_NEXT(a_acc_dec, clk, arst_n, in_valid && !in_stall, state_q == ST_DEC_L, "no decode")
	`CHK_NOW(a_emit_prev, clk, arst_n, out_load, have_prev_q, "result without previous frame")
	`CHK_NEXT(a_last_done, clk, arst_n, out_load && out_last, state_q == ST_CHECK ##1 state_q == ST_DONE, "open frame")

endmodule

FILE: sim/testbench.sv
// Testbench for the linear interpolation audio resampler: driver, monitor and predictor.
`timescale 1ns / 1ps
module testbench;
	import lires_pkg::*;

	localparam longint PH_ONE   = 64'd1 << 28;
	localparam longint MIN_STEP = PH_ONE / 8;
	localparam int     MAX_OUT  = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	lires_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lires_out_t out_data;

	linear_interp_audio_resampler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the format registers and the interpolation state
	logic       fmt_float = 1'b0;
	logic [2:0] fmt_size = SZ_16;
	logic [5:0] fmt_valid = 6'd16;
	logic       fmt_stereo = 1'b1;
	int         prev_l = 0, prev_r = 0;
	bit         have_prev = 0;
	longint     phase_acc = 0;

	lires_in_t  frame_q[$];
	lires_out_t sample_q[$];
	int         sender_idle_pct = 0;
	int         recv_stall_pct = 0;
	bit         hold_req = 0;
	int         hold_cnt = 0;
	int         mismatches = 0;

	function automatic longint unsigned rne_u(longint unsigned m, int unsigned sh);
		longint unsigned q, rem, half;
		if (sh == 0) return m;
		if (sh > 63) return 0;
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) q++;
		return q;
	endfunction

	function automatic longint rne_s(longint t, int unsigned sh);
		longint unsigned m;
		m = (t < 0) ? longint'(-t) : t;
		m = rne_u(m, sh);
		return (t < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic int sat_q(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return int'(v);
	endfunction

	function automatic int decode_pcm(logic [63:0] raw);
		int unsigned bits, vb, k;
		longint unsigned u, mag;
		longint s;
		case (fmt_size)
			SZ_8:  return (int'(raw[7:0]) - 128) * 65536;
			SZ_16: bits = 16;
			SZ_24: bits = 24;
			SZ_32: bits = 32;
			default: return 0;
		endcase
		vb = fmt_valid;
		if (vb == 0 || vb > bits) vb = bits;
		u = raw & ((64'd1 << bits) - 1);
		s = longint'(u);
		if ((u >> (bits - 1)) & 1) s -= longint'(64'd1 << bits);
		k = bits - vb;
		// drop the unused low bits, rounding toward minus infinity
		if (k > 0) begin
			if (s < 0) begin
				mag = longint'(-s);
				s = -longint'((mag + ((64'd1 << k) - 1)) >> k);
			end else
				s = longint'(longint'(s) >>> k);
		end
		if (vb <= 24) s = s * longint'(64'd1 << (24 - vb));
		else s = rne_s(s, vb - 24);
		return sat_q(s);
	endfunction

	function automatic int decode_ieee(logic [63:0] raw, int unsigned ebits, int unsigned mbits);
		longint unsigned m, ef, mag;
		bit neg;
		longint bias, e, s;
		m = raw & ((64'd1 << mbits) - 1);
		ef = (raw >> mbits) & ((64'd1 << ebits) - 1);
		neg = raw[mbits + ebits];
		bias = longint'((64'd1 << (ebits - 1)) - 1);
		// NaN and infinity decode as silence
		if (ef == ((64'd1 << ebits) - 1)) return 0;
		if (ef == 0) e = 1 - bias;
		else begin
			e = longint'(ef) - bias;
			m |= 64'd1 << mbits;
		end
		if (m == 0) return 0;
		if (e >= 0) mag = 64'd1 << 23;
		else begin
			s = e - longint'(mbits) + 23;
			if (s >= 0) mag = m << s;
			else if (s < -63) mag = 0;
			else mag = rne_u(m, int'(-s));
			if (mag > (64'd1 << 23)) mag = 64'd1 << 23;
		end
		return sat_q(neg ? -longint'(mag) : longint'(mag));
	endfunction

	function automatic int decode_sample(logic [63:0] raw);
		if (!fmt_float) return decode_pcm(raw);
		if (fmt_size == SZ_32) return decode_ieee({32'd0, raw[31:0]}, 8, 23);
		if (fmt_size == SZ_64) return decode_ieee(raw, 11, 52);
		return 0;
	endfunction

	function automatic logic [15:0] interp16(int a, int b, longint frac);
		longint t, v;
		t = longint'(a) * PH_ONE + (longint'(b) - longint'(a)) * frac;
		v = rne_s(t, 28);
		if (v >= 8388352) return 16'sd32767;
		if (v <= -8388608) return 16'h8000;
		return 16'(rne_s(v * 32767, 23));
	endfunction

	// Compute the output frames caused by one accepted input frame
	task automatic predict_frames(lires_in_t f);
		longint stp, ph;
		int cl, cr, n;
		lires_out_t o;
		cl = 0;
		cr = 0;
		n = 0;
		stp = f.step;
		if (stp < MIN_STEP) stp = MIN_STEP;
		if (f.discontinuity) begin
			phase_acc = 0;
			have_prev = 0;
			prev_l = 0;
			prev_r = 0;
		end
		if (!f.silent) begin
			cl = decode_sample(f.left_raw);
			cr = fmt_stereo ? decode_sample(f.right_raw) : cl;
		end
		if (!have_prev) begin
			prev_l = cl;
			prev_r = cr;
			have_prev = 1;
			return;
		end
		ph = phase_acc;
		while (ph < PH_ONE && n < MAX_OUT) begin
			o.left_out = interp16(prev_l, cl, ph);
			o.right_out = interp16(prev_r, cr, ph);
			o.last = 1'b0;
			sample_q.insert(sample_q.size(), o);
			n++;
			ph += stp;
		end
		if (n > 0) sample_q[sample_q.size() - 1].last = 1'b1;
		ph = (ph >= PH_ONE) ? ph - PH_ONE : 0;
		prev_l = cl;
		prev_r = cr;
		if (f.packet_last && ph > stp + PH_ONE) ph = 0;
		phase_acc = ph & 64'hFFFF_FFFF;
	endtask

	// Driver: offer queued frames, hold a stalled one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_stall) begin
			in_valid <= 1'b1;
		end else begin
			if (in_valid) predict_frames(in_data);
			if (frame_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= frame_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req) hold_cnt <= 400;
		else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= (hold_cnt > 1) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: compare each output transaction with the oldest expected frame
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sample_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output frame %h", out_data);
			end else if (out_data !== sample_q[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected L=%0d R=%0d last=%0d, got L=%0d R=%0d last=%0d",
						sample_q[0].left_out, sample_q[0].right_out, sample_q[0].last,
						out_data.left_out, out_data.right_out, out_data.last);
				void'(sample_q.pop_front());
			end else begin
				void'(sample_q.pop_front());
			end
		end
	end

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_IS_FLOAT: fmt_float = val[0];
			REG_SIZE:     fmt_size = val[2:0];
			REG_VALID:    fmt_valid = val[5:0];
			REG_STEREO:   fmt_stereo = val[0];
			default:      ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_format(bit flt, logic [2:0] sz, logic [5:0] vb, bit st);
		write_reg(REG_IS_FLOAT, CFG_DATA_W'(flt));
		write_reg(REG_SIZE, CFG_DATA_W'(sz));
		write_reg(REG_VALID, vb);
		write_reg(REG_STEREO, CFG_DATA_W'(st));
	endtask

	// Wait until every frame is taken and every result has come, then let the block settle
	task automatic drain();
		while (frame_q.size() > 0 || in_valid || sample_q.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_raw();
		logic [63:0] r;
		logic [10:0] e64;
		logic [7:0]  e32;
		r = {$urandom, $urandom};
		if (fmt_float && fmt_size == SZ_32) begin
			case ($urandom_range(15))
				0: e32 = 8'd0;
				1: e32 = 8'd255;
				2: e32 = 8'($urandom_range(127, 254));
				default: e32 = 8'($urandom_range(90, 126));
			endcase
			r[30:23] = e32;
		end else if (fmt_float) begin
			case ($urandom_range(15))
				0: e64 = 11'd0;
				1: e64 = 11'd2047;
				2: e64 = 11'($urandom_range(1023, 2046));
				3: e64 = 11'($urandom_range(1, 900));
				default: e64 = 11'($urandom_range(990, 1022));
			endcase
			r[62:52] = e64;
		end else begin
			case ($urandom_range(11))
				0: r = '0;
				1: r = '1;
				2: r = 64'h0000_0000_8000_8080;
				3: r = 64'h0000_0000_7FFF_FF7F;
				4: r = 64'h0000_0000_0080_0000;
				5: r = 64'h0000_0000_7F7F_FFFF;
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic lires_in_t rand_frame();
		lires_in_t f;
		f.left_raw = rand_raw();
		f.right_raw = rand_raw();
		case ($urandom_range(9))
			0: f.step = STEP_W'($urandom_range(0, 33554431));
			1: f.step = STEP_W'($urandom);
			default: f.step = STEP_W'($urandom_range(150000000, 420000000));
		endcase
		f.silent = ($urandom_range(19) == 0);
		f.discontinuity = ($urandom_range(24) == 0);
		f.packet_last = ($urandom_range(4) == 0);
		return f;
	endfunction

	task automatic push_frame(logic [63:0] l, logic [63:0] r, logic [STEP_W-1:0] stp,
			bit sil, bit disc, bit pl);
		lires_in_t f;
		f.left_raw = l;
		f.right_raw = r;
		f.step = stp;
		f.silent = sil;
		f.discontinuity = disc;
		f.packet_last = pl;
		frame_q.insert(frame_q.size(), f);
	endtask

	task automatic run_random(int n, int mode);
		case (mode % 4)
			0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin sender_idle_pct = 80; recv_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
			default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
		endcase
		repeat (n) frame_q.insert(frame_q.size(), rand_frame());
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_format(1'b0, SZ_16, 6'd16, 1'b1);

		// Directed: first frame, extremes, saturated step, silence, recovery
		push_frame(64'h7FFF, 64'h8000, 30'd268435456, 0, 0, 0);
		push_frame(64'h8000, 64'h7FFF, 30'd0, 0, 0, 0);
		push_frame(64'hFFFF_FFFF_FFFF_7FFF, 64'h0000_0000_0000_8000, 30'h3FFF_FFFF, 0, 0, 0);
		push_frame(64'h1234, 64'hFEDC, 30'd33554432, 0, 0, 1);
		push_frame(64'h0001, 64'hFFFF, 30'd100000000, 1, 0, 0);
		push_frame(64'h4000, 64'hC000, 30'd268435456, 0, 1, 0);
		push_frame(64'h7FFF, 64'h8000, 30'd134217728, 0, 0, 0);
		push_frame(64'h0000, 64'h0000, 30'h3FFF_FFFF, 0, 0, 0);
		push_frame(64'h5555, 64'hAAAA, 30'h3FFF_FFFF, 0, 0, 0);
		push_frame(64'hAAAA, 64'h5555, 30'd33554432, 0, 0, 1);
		push_frame(64'hFFFF, 64'h0001, 30'd268435455, 0, 0, 1);
		push_frame(64'h8000, 64'h8000, 30'd268435457, 0, 0, 0);
		push_frame(64'h7FFF, 64'h7FFF, 30'd300000000, 0, 0, 0);
		drain();

		run_random(30, 1);
		set_format(1'b0, SZ_8, 6'd8, 1'b0);
		run_random(25, 2);
		set_format(1'b0, SZ_24, 6'd20, 1'b1);
		run_random(25, 3);

		// Block fills up while the receiver holds off; the sender offers frames without pause
		set_format(1'b0, SZ_32, 6'd32, 1'b1);
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (15) frame_q.insert(frame_q.size(), rand_frame());
		drain();
		run_random(15, 0);

		set_format(1'b0, SZ_32, 6'd28, 1'b1);
		run_random(20, 1);
		set_format(1'b1, SZ_32, 6'd32, 1'b1);
		run_random(30, 2);
		set_format(1'b1, SZ_64, 6'd32, 1'b0);
		run_random(30, 3);
		set_format(1'b1, SZ_64, 6'd32, 1'b1);
		run_random(20, 0);

		// Malformed formats and out-of-range valid bits
		set_format(1'b0, SZ_16, 6'd0, 1'b1);
		run_random(10, 1);
		set_format(1'b0, SZ_24, 6'd63, 1'b1);
		run_random(10, 2);
		set_format(1'b0, SZ_64, 6'd16, 1'b1);
		run_random(8, 3);
		set_format(1'b1, SZ_16, 6'd1, 1'b0);
		run_random(8, 0);
		set_format(1'b1, 3'd7, 6'd1, 1'b1);
		run_random(8, 1);
		set_format(1'b0, SZ_16, 6'd1, 1'b1);
		run_random(10, 3);

		if (mismatches == 0 && sample_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
